@@ rtl/tsb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tsb_pkg;

  localparam int unsigned WaitW    = 16;
  localparam int unsigned BlinkW   = 16;
  localparam int unsigned DegW     = 7;
  localparam int unsigned AngleW   = 8;
  localparam int unsigned ModeW    = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [WaitW-1:0]  WaitReset  = WaitW'(1000);
  localparam logic [BlinkW-1:0] BlinkReset = BlinkW'(100);
  localparam logic [DegW-1:0]   EnterReset = DegW'(40);
  localparam logic [DegW-1:0]   ExitReset  = DegW'(30);

  typedef enum logic [ModeW-1:0] {
    ModeIdle  = 2'd0,
    ModeWait  = 2'd1,
    ModeLeft  = 2'd2,
    ModeRight = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWait  = 2'd0,
    CfgBlink = 2'd1,
    CfgEnter = 2'd2,
    CfgExit  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [WaitW-1:0]  wait_ticks;
    logic [BlinkW-1:0] period;
    logic [DegW-1:0]   enter_deg;
    logic [DegW-1:0]   exit_deg;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic              q_lsb;
    logic [BlinkW-1:0] rem;
  } div_res_t;

endpackage

`default_nettype wire

@@ rtl/tsb_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface tsb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   button_pin;
  logic signed [tsb_pkg::AngleW-1:0]      tilt_angle;

  modport source (output valid, output button_pin, output tilt_angle, input ready);
  modport sink   (input valid, input button_pin, input tilt_angle, output ready);
endinterface

interface tsb_out_if;
  logic                      valid;
  logic                      ready;
  logic                      left_lamp;
  logic                      right_lamp;
  logic [tsb_pkg::ModeW-1:0] mode;

  modport source (output valid, output left_lamp, output right_lamp, output mode,
                  input ready);
  modport sink   (input valid, input left_lamp, input right_lamp, input mode,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/tsb_blink_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsb_blink_div #(
  parameter int unsigned TimeW = 32
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [TimeW-1:0]               dividend_i,
  input  wire logic [tsb_pkg::BlinkW-1:0]     divisor_i,
  output      logic                           busy_o,
  output      tsb_pkg::div_res_t              res_o
);

  localparam int unsigned BW   = tsb_pkg::BlinkW;
  localparam int unsigned CntW = $clog2(TimeW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [TimeW-1:0] dvd_q;
  logic [BW-1:0]   dvs_q;
  logic [BW-1:0]   rem_q;

  logic [BW:0]     rem_sh;
  logic            ge;
  logic [BW-1:0]   rem_d;
  logic            last;

  // one quotient bit per cycle, most significant first
  always_comb begin
    rem_sh = {rem_q, dvd_q[TimeW-1]};
    ge     = rem_sh >= {1'b0, dvs_q};
    rem_d  = ge ? BW'(rem_sh - {1'b0, dvs_q}) : rem_sh[BW-1:0];
    last   = cnt_q == CntW'(TimeW - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[TimeW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign busy_o      = busy_q;
  assign res_o.done  = busy_q && last;
  assign res_o.q_lsb = ge;
  assign res_o.rem   = rem_d;

endmodule

`default_nettype wire

@@ rtl/tsb_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tsb_core #(
  parameter int unsigned DebDepth = 5,
  parameter int unsigned TimeW    = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                step_i,
  input  wire logic                                button_pin_i,
  input  wire logic signed [tsb_pkg::AngleW-1:0]   tilt_angle_i,
  input  wire tsb_pkg::cfg_t                       cfg_i,
  input  wire tsb_pkg::div_res_t                   div_i,
  input  wire logic                                div_busy_i,
  output      logic [TimeW-1:0]                    elapsed_o,
  output      logic                                left_lamp_o,
  output      logic                                right_lamp_o,
  output      tsb_pkg::mode_e                      mode_o
);

  localparam int unsigned BW = tsb_pkg::BlinkW;
  localparam int unsigned AW = tsb_pkg::AngleW;

  logic [DebDepth-1:0] deb_q, deb_d;
  tsb_pkg::mode_e      mode_q, mode_d;
  logic                pf_q, pf_d;
  logic                armed_q, armed_d;
  logic                lamp_l_q, lamp_l_d;
  logic                lamp_r_q, lamp_r_d;
  logic [TimeW-1:0]    wait_cnt_q, wait_cnt_d;
  logic [TimeW-1:0]    el_q, el_d;
  logic [BW-1:0]       rem_q, rem_d;
  logic                par_q, par_d;

  logic [TimeW-1:0]    wait_inc;
  logic [TimeW-1:0]    el_inc;
  logic [BW-1:0]       rem_inc;
  logic                par_inc;
  logic                all_p;
  logic                all_r;
  logic [AW-1:0]       mag;
  logic                over_enter;
  logic                under_exit;
  logic                lit;

  always_comb begin
    deb_d = DebDepth'({deb_q, ~button_pin_i});
    all_p = &deb_d;
    all_r = ~|deb_d;

    mag        = tilt_angle_i[AW-1] ? AW'(-tilt_angle_i) : AW'(tilt_angle_i);
    over_enter = mag > {1'b0, cfg_i.enter_deg};
    under_exit = mag < {1'b0, cfg_i.exit_deg};

    wait_inc = wait_cnt_q + TimeW'(1);
    el_inc   = el_q + TimeW'(1);
    if (&el_q) begin
      rem_inc = '0;
      par_inc = 1'b0;
    end else if (({1'b0, rem_q} + (BW+1)'(1)) == {1'b0, cfg_i.period}) begin
      rem_inc = '0;
      par_inc = ~par_q;
    end else begin
      rem_inc = rem_q + BW'(1);
      par_inc = par_q;
    end
    lit = ~par_inc;

    mode_d     = mode_q;
    pf_d       = pf_q;
    armed_d    = armed_q;
    lamp_l_d   = lamp_l_q;
    lamp_r_d   = lamp_r_q;
    wait_cnt_d = wait_inc;
    el_d       = el_inc;
    rem_d      = rem_inc;
    par_d      = par_inc;

    unique case (mode_q)
      tsb_pkg::ModeIdle: begin
        lamp_l_d = 1'b0;
        lamp_r_d = 1'b0;
        if (!pf_q && all_p) begin
          pf_d = 1'b1;
        end else if (pf_q && all_r) begin
          pf_d       = 1'b0;
          wait_cnt_d = '0;
          mode_d     = tsb_pkg::ModeWait;
        end
      end
      tsb_pkg::ModeWait: begin
        if (wait_inc > TimeW'(cfg_i.wait_ticks) && !pf_q && all_r) begin
          el_d   = '0;
          rem_d  = '0;
          par_d  = 1'b0;
          mode_d = tsb_pkg::ModeLeft;
        end else if (!pf_q && all_p) begin
          pf_d = 1'b1;
        end else if (pf_q && all_r) begin
          pf_d   = 1'b0;
          el_d   = '0;
          rem_d  = '0;
          par_d  = 1'b0;
          mode_d = tsb_pkg::ModeRight;
        end
      end
      tsb_pkg::ModeLeft, tsb_pkg::ModeRight: begin
        armed_d = armed_q | over_enter;
        if (mode_q == tsb_pkg::ModeLeft) begin
          lamp_l_d = lit;
        end else begin
          lamp_r_d = lit;
        end
        if (armed_d && under_exit) begin
          armed_d = 1'b0;
          mode_d  = tsb_pkg::ModeIdle;
        end else if (!pf_q && all_p) begin
          pf_d = 1'b1;
        end else if (pf_q && all_r) begin
          pf_d   = 1'b0;
          mode_d = tsb_pkg::ModeIdle;
        end
      end
      default: begin
        mode_d = tsb_pkg::ModeIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q      <= '0;
      mode_q     <= tsb_pkg::ModeIdle;
      pf_q       <= 1'b0;
      armed_q    <= 1'b0;
      lamp_l_q   <= 1'b0;
      lamp_r_q   <= 1'b0;
      wait_cnt_q <= '0;
      el_q       <= '0;
      rem_q      <= '0;
      par_q      <= 1'b0;
    end else if (step_i) begin
      deb_q      <= deb_d;
      mode_q     <= mode_d;
      pf_q       <= pf_d;
      armed_q    <= armed_d;
      lamp_l_q   <= lamp_l_d;
      lamp_r_q   <= lamp_r_d;
      wait_cnt_q <= wait_cnt_d;
      el_q       <= el_d;
      rem_q      <= rem_d;
      par_q      <= par_d;
    end else if (div_i.done) begin
      // reload blink phase after a period change
      rem_q <= div_i.rem;
      par_q <= div_i.q_lsb;
    end
  end

  assign elapsed_o    = el_q;
  assign left_lamp_o  = lamp_l_d;
  assign right_lamp_o = lamp_r_d;
  assign mode_o       = mode_d;

  a_rem_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !div_busy_i |-> rem_q < cfg_i.period)
    else $error("blink remainder out of range");

  a_wait_dark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tsb_pkg::ModeWait || mode_q == tsb_pkg::ModeIdle) && !step_i
      |=> mode_q != tsb_pkg::ModeWait || (!lamp_l_q && !lamp_r_q))
    else $error("lamp lit while waiting");

  a_left_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == tsb_pkg::ModeLeft |-> !lamp_r_q)
    else $error("right lamp lit during left signal");

  a_right_only : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == tsb_pkg::ModeRight |-> !lamp_l_q)
    else $error("left lamp lit during right signal");

endmodule

`default_nettype wire

@@ rtl/turn_signal_button_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Beat fields
// in_i      in   button_pin (0 = pressed), tilt_angle (signed degrees)
// out_o     out  left_lamp, right_lamp, mode
// cfg       in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One tick per cycle while out_o takes its beats and no divide runs: a beat
// waits in the input register, its result leaves from the output register.
// A write of blink_ticks starts a serial divide that realigns the blink
// phase; a beat in the input register waits until it ends.
// rst_ni clears all control state and loads the register defaults.
// A stalled out_o holds its beat; one more input beat is still taken.

module turn_signal_button_controller #(
  parameter int unsigned DEBOUNCE_DEPTH = 5,
  parameter int unsigned TIME_WIDTH     = 32
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  tsb_in_if.sink                                in_i,
  tsb_out_if.source                             out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tsb_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [tsb_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned BW = tsb_pkg::BlinkW;
  localparam int unsigned DW = tsb_pkg::DegW;
  localparam int unsigned AW = tsb_pkg::AngleW;

  logic [tsb_pkg::WaitW-1:0] wait_q;
  logic [BW-1:0]             blink_q;
  logic [DW-1:0]             enter_q;
  logic [DW-1:0]             exit_q;
  tsb_pkg::cfg_t             cfg;
  tsb_pkg::cfg_idx_e         cfg_idx;
  logic [BW-1:0]             new_period;
  logic                      div_start;

  logic                      in_valid_q;
  logic                      button_q;
  logic signed [AW-1:0]      tilt_q;
  logic                      out_valid_q;
  logic                      left_q;
  logic                      right_q;
  tsb_pkg::mode_e            mode_q;

  logic                      step;
  logic                      div_busy;
  tsb_pkg::div_res_t         div_res;
  logic [TIME_WIDTH-1:0]     elapsed;
  logic                      left_d;
  logic                      right_d;
  tsb_pkg::mode_e            mode_d;

  assign cfg_idx    = tsb_pkg::cfg_idx_e'(cfg_idx_i);
  assign new_period = (cfg_data_i == '0) ? BW'(1) : cfg_data_i;
  assign div_start  = cfg_we_i && cfg_idx == tsb_pkg::CfgBlink;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= tsb_pkg::WaitReset;
      blink_q <= tsb_pkg::BlinkReset;
      enter_q <= tsb_pkg::EnterReset;
      exit_q  <= tsb_pkg::ExitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx)
        tsb_pkg::CfgWait:  wait_q  <= cfg_data_i;
        tsb_pkg::CfgBlink: blink_q <= new_period;
        tsb_pkg::CfgEnter: enter_q <= cfg_data_i[DW-1:0];
        tsb_pkg::CfgExit:  exit_q  <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.wait_ticks = wait_q;
    cfg.period     = blink_q;
    cfg.enter_deg  = enter_q;
    cfg.exit_deg   = exit_q;
  end

  assign step        = in_valid_q && (!out_valid_q || out_o.ready) && !div_busy;
  assign in_i.ready  = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      button_q <= in_i.button_pin;
      tilt_q   <= in_i.tilt_angle;
    end
    if (step) begin
      left_q  <= left_d;
      right_q <= right_d;
      mode_q  <= mode_d;
    end
  end

  tsb_blink_div #(
    .TimeW (TIME_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (elapsed),
    .divisor_i  (new_period),
    .busy_o     (div_busy),
    .res_o      (div_res)
  );

  tsb_core #(
    .DebDepth (DEBOUNCE_DEPTH),
    .TimeW    (TIME_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .button_pin_i (button_q),
    .tilt_angle_i (tilt_q),
    .cfg_i        (cfg),
    .div_i        (div_res),
    .div_busy_i   (div_busy),
    .elapsed_o    (elapsed),
    .left_lamp_o  (left_d),
    .right_lamp_o (right_d),
    .mode_o       (mode_d)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.left_lamp  = left_q;
  assign out_o.right_lamp = right_q;
  assign out_o.mode       = mode_q;

  a_no_step_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !step)
    else $error("tick processed during phase realign");

  a_step_makes_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("processed tick produced no beat");

  a_step_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !out_valid_q || out_o.ready)
    else $error("result overwritten before taken");

endmodule

`default_nettype wire
